FILE: rtl/bipolar_coordinate_warp_top_macros.svh
// ----------------------------------------------------------------------------
// Bipolar warp assertion macros
// Concurrent assertion shorthands clocked on clock, with and without reset.
// ----------------------------------------------------------------------------
`ifndef BIPOLAR_COORDINATE_WARP_TOP_MACROS_SVH
`define BIPOLAR_COORDINATE_WARP_TOP_MACROS_SVH

// checked only while out of reset
`define BCW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define BCW_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: rtl/bcw_pkg.sv
// ----------------------------------------------------------------------------
// Bipolar warp package
// Payload types, CORDIC datapath types, angle tables and arithmetic helpers.
// ----------------------------------------------------------------------------
package bcw_pkg;

   // datapath widths (independent of the input format)
   localparam int CW  = 44;   // circular x/y
   localparam int ZW  = 34;   // binary angle accumulator
   localparam int HW  = 45;   // hyperbolic x/y
   localparam int HZW = 36;   // hyperbolic angle accumulator

   localparam logic signed [32:0] LN2_Q32     = 33'sd2977044472;
   localparam logic signed [31:0] INV_2PI_Q32 = 32'sd683565276;
   localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
   localparam logic signed [HW-1:0] HYP_ONE = 45'sd1099511627776;   // 1.0 at 40 fraction bits

   typedef enum logic [0:0] {
      CSR_WEIGHT = 1'b0,
      CSR_SHIFT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic               skipped;
   } rsp_type;

   typedef struct packed {
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      logic signed [ZW-1:0] z;
   } circ_type;

   typedef struct packed {
      logic signed [HW-1:0]  hx;
      logic signed [HW-1:0]  hy;
      logic signed [HZW-1:0] z;
   } hyp_type;

   typedef struct packed {
      logic               skip;
      logic signed [31:0] dz;
      logic signed [39:0] eln;   // exponent difference times ln2, Q32
   } side_type;

   // atan(2^-k) in binary angle units (2^32 per turn)
   function automatic logic [31:0] atan_val(input int unsigned k);
      case (k)
         0:  return 32'h20000000;
         1:  return 32'h12E4051E;
         2:  return 32'h09FB385B;
         3:  return 32'h051111D4;
         4:  return 32'h028B0D43;
         5:  return 32'h0145D7E1;
         6:  return 32'h00A2F61E;
         7:  return 32'h00517C55;
         8:  return 32'h0028BE53;
         9:  return 32'h00145F2F;
         10: return 32'h000A2F98;
         11: return 32'h000517CC;
         12: return 32'h00028BE6;
         13: return 32'h000145F3;
         14: return 32'h0000A2FA;
         15: return 32'h0000517D;
         16: return 32'h000028BE;
         17: return 32'h0000145F;
         18: return 32'h00000A30;
         19: return 32'h00000518;
         20: return 32'h0000028C;
         21: return 32'h00000146;
         22: return 32'h000000A3;
         23: return 32'h00000051;
         24: return 32'h00000029;
         25: return 32'h00000014;
         26: return 32'h0000000A;
         27: return 32'h00000005;
         28: return 32'h00000003;
         29: return 32'h00000001;
         30: return 32'h00000001;
         default: return 32'h00000000;
      endcase
   endfunction

   // atanh(2^-k) in Q32
   function automatic logic [32:0] atanh_val(input int unsigned k);
      case (k)
         1:  return 33'd2359251925;
         2:  return 33'd1096989674;
         3:  return 33'd539693625;
         4:  return 33'd268785803;
         5:  return 33'd134261444;
         6:  return 33'd67114326;
         7:  return 33'd33555115;
         8:  return 33'd16777301;
         9:  return 33'd8388619;
         10: return 33'd4194305;
         11: return 33'd2097152;
         12: return 33'd1048576;
         13: return 33'd524288;
         14: return 33'd262144;
         15: return 33'd131072;
         16: return 33'd65536;
         17: return 33'd32768;
         18: return 33'd16384;
         19: return 33'd8192;
         20: return 33'd4096;
         21: return 33'd2048;
         22: return 33'd1024;
         23: return 33'd512;
         24: return 33'd256;
         25: return 33'd128;
         26: return 33'd64;
         27: return 33'd32;
         28: return 33'd16;
         29: return 33'd8;
         30: return 33'd4;
         31: return 33'd2;
         32: return 33'd1;
         default: return 33'd0;
      endcase
   endfunction

   // hyperbolic shift for iteration n; shifts 4 and 13 are used twice
   function automatic int unsigned hyp_shift(input int unsigned n);
      int unsigned k;
      if (n < 4) k = n + 1;
      else if (n < 14) k = n;
      else k = n - 1;
      if (k > 32) k = 32;
      return k;
   endfunction

   function automatic logic [5:0] msb64(input logic [63:0] v);
      logic [5:0] e;
      e = '0;
      for (int i = 1; i < 64; i++) begin
         if (v[i]) e = 6'(i);
      end
      return e;
   endfunction

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic signed [32:0] n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

   // round half up by sh bits, then saturate to 32-bit signed
   function automatic logic signed [31:0] round_sat(input logic signed [71:0] v,
                                                    input int unsigned sh);
      logic signed [71:0] r;
      r = (v + (72'sd1 <<< (sh - 1))) >>> sh;
      if (r > 72'sd2147483647) return 32'sh7FFFFFFF;
      else if (r < -72'sd2147483648) return 32'sh80000000;
      else return r[31:0];
   endfunction

   function automatic circ_type circ_step(input circ_type c, input int unsigned k,
                                          input logic [31:0] a);
      circ_type n;
      logic signed [ZW-1:0] az;
      az = $signed(ZW'(a));
      if (c.vy > 0) begin
         n.vx = c.vx + (c.vy >>> k);
         n.vy = c.vy - (c.vx >>> k);
         n.z  = c.z + az;
      end else begin
         n.vx = c.vx - (c.vy >>> k);
         n.vy = c.vy + (c.vx >>> k);
         n.z  = c.z - az;
      end
      return n;
   endfunction

   function automatic hyp_type hyp_step(input hyp_type h, input int unsigned k,
                                        input logic [32:0] a);
      hyp_type n;
      logic signed [HZW-1:0] az;
      az = $signed(HZW'(a));
      if (h.hy > 0) begin
         n.hx = h.hx - (h.hy >>> k);
         n.hy = h.hy - (h.hx >>> k);
         n.z  = h.z + az;
      end else begin
         n.hx = h.hx + (h.hy >>> k);
         n.hy = h.hy + (h.hx >>> k);
         n.z  = h.z - az;
      end
      return n;
   endfunction

endpackage

FILE: rtl/bcw_if.sv
// ----------------------------------------------------------------------------
// Bipolar warp stream interfaces
// Valid/ready channels for point requests and warp responses.
// ----------------------------------------------------------------------------
interface bcw_req_if;
   logic             valid;
   logic             ready;
   bcw_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface bcw_rsp_if;
   logic             valid;
   logic             ready;
   bcw_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/bcw_cordic.sv
// ----------------------------------------------------------------------------
// Bipolar warp CORDIC pipeline
// One circular (vectoring) and two hyperbolic lanes, one iteration per stage.
// ----------------------------------------------------------------------------
module bcw_cordic #(
   parameter int N = 20
) (
   input  logic              clock,
   input  logic [N-1:0]      en,
   input  bcw_pkg::circ_type circ_init,
   input  bcw_pkg::hyp_type  hn_init,
   input  bcw_pkg::hyp_type  hd_init,
   output bcw_pkg::circ_type circ_out,
   output bcw_pkg::hyp_type  hn_out,
   output bcw_pkg::hyp_type  hd_out
);

   bcw_pkg::circ_type circ_ff [N];
   bcw_pkg::hyp_type  hn_ff   [N];
   bcw_pkg::hyp_type  hd_ff   [N];

   for (genvar gi = 0; gi < N; gi++) begin : g_stage
      localparam int unsigned KC = gi % 32;
      localparam int unsigned KH = bcw_pkg::hyp_shift(gi);

      bcw_pkg::circ_type c_src;
      bcw_pkg::hyp_type  hn_src, hd_src;
      bcw_pkg::circ_type c_in;
      bcw_pkg::hyp_type  hn_in, hd_in;

      if (gi == 0) begin : g_first
         assign c_src  = circ_init;
         assign hn_src = hn_init;
         assign hd_src = hd_init;
      end else begin : g_rest
         assign c_src  = circ_ff[gi-1];
         assign hn_src = hn_ff[gi-1];
         assign hd_src = hd_ff[gi-1];
      end

      always_comb begin
         c_in  = bcw_pkg::circ_step(c_src, KC, bcw_pkg::atan_val(KC));
         hn_in = bcw_pkg::hyp_step(hn_src, KH, bcw_pkg::atanh_val(KH));
         hd_in = bcw_pkg::hyp_step(hd_src, KH, bcw_pkg::atanh_val(KH));
      end

      always_ff @(posedge clock) begin
         if (en[gi]) begin
            circ_ff[gi] <= c_in;
            hn_ff[gi]   <= hn_in;
            hd_ff[gi]   <= hd_in;
         end
      end
   end

   assign circ_out = circ_ff[N-1];
   assign hn_out   = hn_ff[N-1];
   assign hd_out   = hd_ff[N-1];

endmodule

FILE: rtl/bipolar_coordinate_warp_top.sv
// ----------------------------------------------------------------------------
// Bipolar coordinate warp
// Fixed-point bipolar warp of a 3-D point with saturated weighted outputs.
// ----------------------------------------------------------------------------
// One point enters per clock and one result leaves per clock in steady state
// while the response is accepted. The pipeline has seven stages of squaring, summing and
// normalization, one stage per CORDIC iteration (atan2 and both logarithms
// run side by side), and five stages of scaling and saturation. Every stage
// holds its own valid bit, so a stalled response only backs up the pipeline
// until the first empty stage. weight and shift are to be written through the
// csr port only while no transaction is in flight; the block does not check it.
`include "bipolar_coordinate_warp_top_macros.svh"

module bipolar_coordinate_warp_top #(
   parameter int FRAC_BITS     = 16,
   parameter int CORDIC_STAGES = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   bcw_req_if.sink                req_chan,
   bcw_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  bcw_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);

   localparam int N      = CORDIC_STAGES;
   localparam int S_IN   = 0;
   localparam int S_MAG  = 1;
   localparam int S_SQ   = 2;
   localparam int S_SUM  = 3;
   localparam int S_ABS  = 4;
   localparam int S_MSB  = 5;
   localparam int S_NORM = 6;
   localparam int S_CORD = 7;
   localparam int S_P1   = S_CORD + N;
   localparam int S_P2   = S_P1 + 1;
   localparam int S_P3   = S_P2 + 1;
   localparam int S_P4   = S_P3 + 1;
   localparam int S_OUT  = S_P4 + 1;
   localparam int NPIPE  = S_OUT + 1;

   localparam logic signed [32:0] ONE  = 33'sd1 <<< FRAC_BITS;
   localparam logic [63:0]        ONE2 = 64'd1 << (2 * FRAC_BITS);
   localparam int unsigned        SHIFT_POS = 30 - FRAC_BITS;

   // ---------------- configuration
   logic signed [31:0] weight_ff;
   logic signed [17:0] shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= 32'sd1 <<< FRAC_BITS;
         shift_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            bcw_pkg::CSR_WEIGHT: weight_ff <= $signed(csr_wdata);
            bcw_pkg::CSR_SHIFT:  shift_ff  <= $signed(csr_wdata[17:0]);
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control
   logic [NPIPE-1:0] valid_ff;
   logic [NPIPE-1:0] en;

   // a stage may load when it or any later stage is empty, or the output drains
   always_comb begin
      for (int i = 0; i < NPIPE; i++) begin
         en[i] = rsp_chan.ready ||
                 ((valid_ff | ((NPIPE'(1) << i) - NPIPE'(1))) != {NPIPE{1'b1}});
      end
   end

   assign req_chan.ready = en[S_IN];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[S_IN]) valid_ff[S_IN] <= req_chan.valid;
         for (int i = 1; i < NPIPE; i++) begin
            if (en[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // ---------------- input register
   bcw_pkg::req_type in_ff;

   always_ff @(posedge clock) begin
      if (en[S_IN]) in_ff <= req_chan.data;
   end

   // ---------------- magnitudes, z product
   logic signed [32:0] xp_in, xm_in;
   logic signed [63:0] pz_in;
   logic [31:0]        mx_ff, my_ff, ap_ff, am_ff;
   logic               yneg1_ff;
   logic signed [63:0] pz_ff;

   always_comb begin
      xp_in = 33'(in_ff.x_in) + ONE;
      xm_in = 33'(in_ff.x_in) - ONE;
      pz_in = weight_ff * in_ff.z_in;
   end

   always_ff @(posedge clock) begin
      if (en[S_MAG]) begin
         mx_ff    <= bcw_pkg::mag33(33'(in_ff.x_in));
         my_ff    <= bcw_pkg::mag33(33'(in_ff.y_in));
         ap_ff    <= bcw_pkg::mag33(xp_in);
         am_ff    <= bcw_pkg::mag33(xm_in);
         yneg1_ff <= in_ff.y_in[31];
         pz_ff    <= pz_in;
      end
   end

   // ---------------- squares
   logic [63:0]        x2_ff, y2_ff, ap2_ff, am2_ff;
   logic [31:0]        my2_ff;
   logic               yneg2_ff;
   logic signed [31:0] dz2_ff;

   always_ff @(posedge clock) begin
      if (en[S_SQ]) begin
         x2_ff    <= mx_ff * mx_ff;
         y2_ff    <= my_ff * my_ff;
         ap2_ff   <= ap_ff * ap_ff;
         am2_ff   <= am_ff * am_ff;
         my2_ff   <= my_ff;
         yneg2_ff <= yneg1_ff;
         dz2_ff   <= bcw_pkg::round_sat(72'(pz_ff), FRAC_BITS);
      end
   end

   // ---------------- sums
   logic [63:0]        s_ff, numer3_ff, denom3_ff;
   logic [31:0]        my3_ff;
   logic               yneg3_ff;
   logic signed [31:0] dz3_ff;

   always_ff @(posedge clock) begin
      if (en[S_SUM]) begin
         s_ff      <= x2_ff + y2_ff;
         numer3_ff <= ap2_ff + y2_ff;
         denom3_ff <= am2_ff + y2_ff;
         my3_ff    <= my2_ff;
         yneg3_ff  <= yneg2_ff;
         dz3_ff    <= dz2_ff;
      end
   end

   // ---------------- vector for atan2, skip detect
   logic [63:0]        ax4_ff, ay4_ff, numer4_ff, denom4_ff;
   logic               xneg4_ff, yneg4_ff, skip4_ff;
   logic signed [31:0] dz4_ff;

   always_ff @(posedge clock) begin
      if (en[S_ABS]) begin
         ax4_ff    <= (s_ff >= ONE2) ? (s_ff - ONE2) : (ONE2 - s_ff);
         xneg4_ff  <= (s_ff < ONE2);
         ay4_ff    <= 64'(my3_ff) << (FRAC_BITS + 1);
         yneg4_ff  <= yneg3_ff;
         numer4_ff <= numer3_ff;
         denom4_ff <= denom3_ff;
         skip4_ff  <= (numer3_ff == '0) || (denom3_ff == '0);
         dz4_ff    <= dz3_ff;
      end
   end

   // ---------------- leading-one positions
   logic [63:0]        amax_in;
   logic [5:0]         ea5_ff, msbn5_ff, msbd5_ff;
   logic [63:0]        ax5_ff, ay5_ff, numer5_ff, denom5_ff;
   logic               xneg5_ff, yneg5_ff, skip5_ff;
   logic signed [31:0] dz5_ff;

   assign amax_in = (ax4_ff > ay4_ff) ? ax4_ff : ay4_ff;

   always_ff @(posedge clock) begin
      if (en[S_MSB]) begin
         ea5_ff    <= bcw_pkg::msb64(amax_in);
         msbn5_ff  <= bcw_pkg::msb64(numer4_ff);
         msbd5_ff  <= bcw_pkg::msb64(denom4_ff);
         ax5_ff    <= ax4_ff;
         ay5_ff    <= ay4_ff;
         numer5_ff <= numer4_ff;
         denom5_ff <= denom4_ff;
         xneg5_ff  <= xneg4_ff;
         yneg5_ff  <= yneg4_ff;
         skip5_ff  <= skip4_ff;
         dz5_ff    <= dz4_ff;
      end
   end

   // ---------------- normalize, CORDIC seeds
   logic [39:0]                    axn_in, ayn_in;
   logic [40:0]                    mn_in, md_in;
   logic signed [bcw_pkg::CW-1:0]  cx_in, cy_in;
   logic signed [6:0]              ediff_in;
   bcw_pkg::circ_type              circ_in;
   bcw_pkg::hyp_type               hn_in, hd_in;
   bcw_pkg::side_type              side_in;

   bcw_pkg::circ_type circ_seed_ff;
   bcw_pkg::hyp_type  hn_seed_ff, hd_seed_ff;
   bcw_pkg::side_type side6_ff;

   always_comb begin
      // vector normalized to a leading one at bit 39
      if (ea5_ff > 6'd39) begin
         axn_in = 40'(ax5_ff >> (ea5_ff - 6'd39));
         ayn_in = 40'(ay5_ff >> (ea5_ff - 6'd39));
      end else begin
         axn_in = 40'(ax5_ff << (6'd39 - ea5_ff));
         ayn_in = 40'(ay5_ff << (6'd39 - ea5_ff));
      end
      // log mantissas in [1,2) with 40 fraction bits
      if (msbn5_ff > 6'd40) mn_in = 41'(numer5_ff >> (msbn5_ff - 6'd40));
      else                  mn_in = 41'(numer5_ff << (6'd40 - msbn5_ff));
      if (msbd5_ff > 6'd40) md_in = 41'(denom5_ff >> (msbd5_ff - 6'd40));
      else                  md_in = 41'(denom5_ff << (6'd40 - msbd5_ff));

      cx_in = xneg5_ff ? -$signed(bcw_pkg::CW'(axn_in)) : $signed(bcw_pkg::CW'(axn_in));
      cy_in = yneg5_ff ? -$signed(bcw_pkg::CW'(ayn_in)) : $signed(bcw_pkg::CW'(ayn_in));

      // pre-rotate by a quarter turn toward the x axis
      if (!yneg5_ff) begin
         circ_in.vx = cy_in;
         circ_in.vy = -cx_in;
         circ_in.z  = bcw_pkg::QUARTER_TURN;
      end else begin
         circ_in.vx = -cy_in;
         circ_in.vy = cx_in;
         circ_in.z  = -bcw_pkg::QUARTER_TURN;
      end

      hn_in.hx = $signed(bcw_pkg::HW'(mn_in)) + bcw_pkg::HYP_ONE;
      hn_in.hy = $signed(bcw_pkg::HW'(mn_in)) - bcw_pkg::HYP_ONE;
      hn_in.z  = '0;
      hd_in.hx = $signed(bcw_pkg::HW'(md_in)) + bcw_pkg::HYP_ONE;
      hd_in.hy = $signed(bcw_pkg::HW'(md_in)) - bcw_pkg::HYP_ONE;
      hd_in.z  = '0;

      ediff_in     = $signed({1'b0, msbn5_ff}) - $signed({1'b0, msbd5_ff});
      side_in.skip = skip5_ff;
      side_in.dz   = dz5_ff;
      side_in.eln  = ediff_in * bcw_pkg::LN2_Q32;
   end

   always_ff @(posedge clock) begin
      if (en[S_NORM]) begin
         circ_seed_ff <= circ_in;
         hn_seed_ff   <= hn_in;
         hd_seed_ff   <= hd_in;
         side6_ff     <= side_in;
      end
   end

   // ---------------- CORDIC iterations
   bcw_pkg::circ_type circ_out;
   bcw_pkg::hyp_type  hn_out, hd_out;

   bcw_cordic #(
      .N (N)
   ) u_cordic (
      .clock     (clock),
      .en        (en[S_CORD +: N]),
      .circ_init (circ_seed_ff),
      .hn_init   (hn_seed_ff),
      .hd_init   (hd_seed_ff),
      .circ_out  (circ_out),
      .hn_out    (hn_out),
      .hd_out    (hd_out)
   );

   bcw_pkg::side_type side_ff [N];

   for (genvar gi = 0; gi < N; gi++) begin : g_side
      if (gi == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (en[S_CORD]) side_ff[0] <= side6_ff;
         end
      end else begin : g_rest
         always_ff @(posedge clock) begin
            if (en[S_CORD + gi]) side_ff[gi] <= side_ff[gi-1];
         end
      end
   end

   // ---------------- half angle with shift, wrap; log difference
   logic signed [40:0] yv_in, yr_in;
   logic signed [31:0] w_in;
   logic signed [41:0] lnr_in, q_full_in;
   logic signed [31:0] w_ff;
   logic signed [33:0] q_ff;
   logic               skip_p1_ff;
   logic signed [31:0] dz_p1_ff;

   always_comb begin
      yv_in     = 41'(circ_out.z >>> 1) - (41'(shift_ff) <<< SHIFT_POS);
      // wrap into (-pi/2, pi/2] with period pi
      yr_in     = yv_in + 41'sd1073741823;
      w_in      = $signed({1'b0, yr_in[30:0]}) - 32'sd1073741823;
      lnr_in    = 42'(side_ff[N-1].eln) + ((42'(hn_out.z) - 42'(hd_out.z)) <<< 1);
      q_full_in = (lnr_in + 42'sd128) >>> 8;
   end

   always_ff @(posedge clock) begin
      if (en[S_P1]) begin
         w_ff       <= w_in;
         q_ff       <= q_full_in[33:0];
         skip_p1_ff <= side_ff[N-1].skip;
         dz_p1_ff   <= side_ff[N-1].dz;
      end
   end

   // ---------------- products
   logic signed [63:0] prody_ff;
   logic signed [65:0] prodq_ff;
   logic               skip_p2_ff;
   logic signed [31:0] dz_p2_ff;

   always_ff @(posedge clock) begin
      if (en[S_P2]) begin
         prody_ff   <= weight_ff * w_ff;
         prodq_ff   <= q_ff * bcw_pkg::INV_2PI_Q32;
         skip_p2_ff <= skip_p1_ff;
         dz_p2_ff   <= dz_p1_ff;
      end
   end

   // ---------------- round dy and scaled log
   logic signed [65:0] d_full_in;
   logic signed [31:0] dy_p3_ff;
   logic signed [33:0] d_ff;
   logic               skip_p3_ff;
   logic signed [31:0] dz_p3_ff;

   assign d_full_in = (prodq_ff + (66'sd1 <<< 31)) >>> 32;

   always_ff @(posedge clock) begin
      if (en[S_P3]) begin
         dy_p3_ff   <= bcw_pkg::round_sat(72'(prody_ff), 30);
         d_ff       <= d_full_in[33:0];
         skip_p3_ff <= skip_p2_ff;
         dz_p3_ff   <= dz_p2_ff;
      end
   end

   // ---------------- weight times log term
   logic signed [65:0] prodx_ff;
   logic signed [31:0] dy_p4_ff;
   logic               skip_p4_ff;
   logic signed [31:0] dz_p4_ff;

   always_ff @(posedge clock) begin
      if (en[S_P4]) begin
         prodx_ff   <= weight_ff * d_ff;
         dy_p4_ff   <= dy_p3_ff;
         skip_p4_ff <= skip_p3_ff;
         dz_p4_ff   <= dz_p3_ff;
      end
   end

   // ---------------- output register
   bcw_pkg::rsp_type out_in, out_ff;

   always_comb begin
      if (skip_p4_ff) begin
         out_in.dx      = '0;
         out_in.dy      = '0;
         out_in.dz      = '0;
         out_in.skipped = 1'b1;
      end else begin
         out_in.dx      = bcw_pkg::round_sat(72'(prodx_ff), 24);
         out_in.dy      = dy_p4_ff;
         out_in.dz      = dz_p4_ff;
         out_in.skipped = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[S_OUT]) out_ff <= out_in;
   end

   assign rsp_chan.valid = valid_ff[S_OUT];
   assign rsp_chan.data  = out_ff;

   // ---------------- assertions
   `BCW_ASSERT(a_skip_zero, rsp_chan.valid && rsp_chan.data.skipped |-> rsp_chan.data.dx == 0 && rsp_chan.data.dy == 0 && rsp_chan.data.dz == 0, "skipped point with nonzero delta")
   `BCW_ASSERT(a_ready_when_drained, !valid_ff[S_OUT] |-> req_chan.ready, "input stalled with empty output stage")
   `BCW_ASSERT(a_accept_lands, req_chan.valid && req_chan.ready |=> valid_ff[S_IN], "accepted transaction not captured")
   `BCW_ASSERT_ALWAYS(a_reset_flush, reset |=> valid_ff == '0, "pipeline not flushed by reset")

endmodule
